// ===== design/inverse_arx_double_round_assert.svh =====
// Assertion macros for the inverse ARX double round.
// Each macro expects clk and rst in scope at the point of use.
`ifndef INVERSE_ARX_DOUBLE_ROUND_ASSERT_SVH
`define INVERSE_ARX_DOUBLE_ROUND_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define IADR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define IADR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IADR_ASSERT_IMPL(lbl, ante, cons, msg)
`define IADR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/iadr_pkg.sv =====
`timescale 1ns / 1ps

package iadr_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;  // word k in bits 32k+31..32k
  typedef logic [3:0]  widx_t;
  typedef logic [4:0]  rot_t;
  typedef logic [2:0]  gsel_t;    // {layer, group}

  // Rotation amounts for the two halves of an inverse quarter round.
  localparam rot_t ROT_B_FIRST  = 5'd7;
  localparam rot_t ROT_D_FIRST  = 5'd8;
  localparam rot_t ROT_B_SECOND = 5'd12;
  localparam rot_t ROT_D_SECOND = 5'd16;

  localparam logic LAYER_DIAG  = 1'b0;
  localparam logic LAYER_COL   = 1'b1;
  localparam logic HALF_FIRST  = 1'b0;
  localparam logic HALF_SECOND = 1'b1;

  // Word groups (a,b,c,d); entries 0..3 diagonals, 4..7 columns.
  localparam widx_t GRP_A [8] = '{4'd3, 4'd2, 4'd1, 4'd0, 4'd3, 4'd2, 4'd1, 4'd0};
  localparam widx_t GRP_B [8] = '{4'd4, 4'd7, 4'd6, 4'd5, 4'd7, 4'd6, 4'd5, 4'd4};
  localparam widx_t GRP_C [8] = '{4'd9, 4'd8, 4'd11, 4'd10, 4'd11, 4'd10, 4'd9, 4'd8};
  localparam widx_t GRP_D [8] = '{4'd14, 4'd13, 4'd12, 4'd15, 4'd15, 4'd14, 4'd13, 4'd12};

  function automatic word_t rotr(word_t v, rot_t n);
    logic [63:0] dbl;
    dbl = {v, v} >> n;
    return dbl[31:0];
  endfunction

  // One half of the inverse quarter round on all four groups of a layer.
  // Groups of one layer are disjoint, so they work side by side.
  function automatic state_t half_layer(state_t s, logic layer, logic half);
    state_t r;
    rot_t   rb;
    rot_t   rd;
    gsel_t  sel;
    widx_t  ia;
    widx_t  ib;
    widx_t  ic;
    widx_t  id;
    word_t  nb;
    r  = s;
    rb = (half == HALF_SECOND) ? ROT_B_SECOND : ROT_B_FIRST;
    rd = (half == HALF_SECOND) ? ROT_D_SECOND : ROT_D_FIRST;
    for (int g = 0; g < 4; g++) begin
      sel   = {layer, 2'(g)};
      ia    = GRP_A[sel];
      ib    = GRP_B[sel];
      ic    = GRP_C[sel];
      id    = GRP_D[sel];
      nb    = rotr(s[ib], rb) ^ s[ic];
      r[ib] = nb;
      r[ic] = s[ic] - s[id];
      r[id] = rotr(s[id], rd) ^ s[ia];
      r[ia] = s[ia] - nb;
    end
    return r;
  endfunction

endpackage

// ===== design/iadr_stage.sv =====
`timescale 1ns / 1ps

// One pipeline register for the 512-bit block with valid/ready flow control.
module iadr_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  iadr_pkg::state_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output iadr_pkg::state_t out_data
);

  logic             valid;
  iadr_pkg::state_t data;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end

endmodule

// ===== design/inverse_arx_double_round.sv =====
// Inverse ARX double round: an accepted block is registered in every stage before m_axis.
// Throughput one block per cycle while the sink holds m_axis_tready high; four-stage
// pipeline, one half quarter-round layer (one 32-bit subtract after a rotate/xor) per stage.
// Reset (rst, synchronous, active high) clears the stage valid bits only;
// no block state is kept, data registers are not reset.
`timescale 1ns / 1ps

module inverse_arx_double_round (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // in_words_0_1, in_words_2_3, ..., in_words_14_15, 64 bits each from bit 0
  input  logic [511:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_words_0_1, out_words_2_3, ..., out_words_14_15, 64 bits each from bit 0
  output logic [511:0] m_axis_tdata
);

  // Pipeline:
  //   stage 1  first half of the four inverse diagonal quarter rounds
  //   stage 2  second half of the diagonals
  //   stage 3  first half of the four inverse column quarter rounds
  //   stage 4  second half of the columns; this register drives m_axis
  // Each stage accepts when empty or when its downstream takes its transaction,
  // so a stalled output freezes only the stages that are full.

  iadr_pkg::state_t in_state;
  iadr_pkg::state_t d1_next, d2_next, d3_next, d4_next;
  iadr_pkg::state_t d1, d2, d3, d4;
  logic             v1, v2, v3;
  logic             r2, r3, r4;

  // Fields pack word 2k low, 2k+1 high, matching the packed word array.
  assign in_state = s_axis_tdata;

  assign d1_next = iadr_pkg::half_layer(in_state, iadr_pkg::LAYER_DIAG, iadr_pkg::HALF_FIRST);
  assign d2_next = iadr_pkg::half_layer(d1, iadr_pkg::LAYER_DIAG, iadr_pkg::HALF_SECOND);
  assign d3_next = iadr_pkg::half_layer(d2, iadr_pkg::LAYER_COL, iadr_pkg::HALF_FIRST);
  assign d4_next = iadr_pkg::half_layer(d3, iadr_pkg::LAYER_COL, iadr_pkg::HALF_SECOND);

  iadr_stage u_stage1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (d1_next),
    .out_valid (v1),
    .out_ready (r2),
    .out_data  (d1)
  );

  iadr_stage u_stage2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (r2),
    .in_data   (d2_next),
    .out_valid (v2),
    .out_ready (r3),
    .out_data  (d2)
  );

  iadr_stage u_stage3 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (r3),
    .in_data   (d3_next),
    .out_valid (v3),
    .out_ready (r4),
    .out_data  (d3)
  );

  // Output register.
  iadr_stage u_stage4 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_ready  (r4),
    .in_data   (d4_next),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (d4)
  );

  assign m_axis_tdata = d4;

  `include "inverse_arx_double_round_assert.svh"

  // A ready sink lets every stage advance, so the input is never blocked.
  `IADR_ASSERT_IMPL(a_ready_chain, m_axis_tready, s_axis_tready, "input blocked with sink ready")
  // Full pipe with a stalled sink must refuse new transactions.
  `IADR_ASSERT_IMPL(a_full_stall, v1 && v2 && v3 && m_axis_tvalid && !m_axis_tready, !s_axis_tready, "accept while full and stalled")
  // An accepted transaction lands in stage 1.
  `IADR_ASSERT_NEXT(a_accept_lands, s_axis_tvalid && s_axis_tready, v1, "accepted block lost")

endmodule

// ===== test/inverse_arx_double_round_test.sv =====
`timescale 1ns / 1ps

module inverse_arx_double_round_test;

  // Run length. The slowest correct run: ~920 blocks, every block waiting out
  // an 85 % idle sender or an 85 % stalled receiver. The bound below covers
  // such a run many times over.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_BLOCKS = 300;
  localparam int DRAIN_CYCLES = 12;   // pipeline is 4 deep; a few spare

  // Keeps the predicted result blocks in input order and compares each
  // output transaction with the oldest one.
  class round_scoreboard;
    logic [511:0] predicted[$];
    int           errors;
    logic [31:0]  st[16];

    function new();
      errors = 0;
    endfunction

    function logic [31:0] ror32(logic [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
    endfunction

    // One inverse quarter round on scratch words a, b, c, d.
    function void unmix_quarter(int a, int b, int c, int d);
      st[b] = ror32(st[b], 7) ^ st[c];
      st[c] = st[c] - st[d];
      st[d] = ror32(st[d], 8) ^ st[a];
      st[a] = st[a] - st[b];
      st[b] = ror32(st[b], 12) ^ st[c];
      st[c] = st[c] - st[d];
      st[d] = ror32(st[d], 16) ^ st[a];
      st[a] = st[a] - st[b];
    endfunction

    function logic [511:0] undo_double_round(logic [511:0] blk);
      logic [511:0] res;
      for (int k = 0; k < 16; k++) st[k] = blk[32*k +: 32];
      // diagonal layer is undone first, then the column layer
      unmix_quarter(3, 4, 9, 14);
      unmix_quarter(2, 7, 8, 13);
      unmix_quarter(1, 6, 11, 12);
      unmix_quarter(0, 5, 10, 15);
      unmix_quarter(3, 7, 11, 15);
      unmix_quarter(2, 6, 10, 14);
      unmix_quarter(1, 5, 9, 13);
      unmix_quarter(0, 4, 8, 12);
      for (int k = 0; k < 16; k++) res[32*k +: 32] = st[k];
      return res;
    endfunction

    function void note_block(logic [511:0] blk);
      predicted.push_back(undo_double_round(blk));
    endfunction

    function void check_block(logic [511:0] got);
      logic [511:0] want;
      if (predicted.size() == 0) begin
        $display("%0t: unexpected result block %h", $time, got);
        errors++;
        return;
      end
      want = predicted.pop_front();
      for (int f = 0; f < 8; f++) begin
        if (got[64*f +: 64] !== want[64*f +: 64]) begin
          $display("%0t: out_words_%0d_%0d expected %h actual %h",
                   $time, 2*f, 2*f + 1, want[64*f +: 64], got[64*f +: 64]);
          errors++;
        end
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [511:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [511:0] m_axis_tdata;

  // idle odds in percent, changed per phase by the main sequence
  int send_idle_pct  = 22;
  int recv_stall_pct = 85;
  int cycles = 0;

  round_scoreboard sb = new();

  inverse_arx_double_round i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Receiver: new tready each cycle, stall odds per phase.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor. Runs right after the edge, before any NBA lands, so it sees the
  // values that the block sampled at this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_block(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_block(m_axis_tdata);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one block and hold it until the transaction happens. Random idle
  // cycles go in front; tvalid stays high across back-to-back blocks.
  task automatic send_block(input logic [511:0] blk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= blk;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Mostly random words, with all-zero, all-one and single-bit words mixed in so
  // that the subtractions see borrow chains end to end.
  function automatic logic [511:0] random_block();
    logic [511:0] blk;
    int           pick;
    for (int k = 0; k < 16; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)       blk[32*k +: 32] = 32'h0000_0000;
      else if (pick < 16) blk[32*k +: 32] = 32'hffff_ffff;
      else if (pick < 20) blk[32*k +: 32] = 32'h1 << $urandom_range(0, 31);
      else                blk[32*k +: 32] = $urandom;
    end
    return blk;
  endfunction

  task automatic send_directed();
    logic [511:0] blk;
    send_block('0);
    send_block('1);
    send_block({16{32'h5555_5555}});
    send_block({16{32'haaaa_aaaa}});
    // each 64-bit field at its maximum alone
    for (int f = 0; f < 8; f++) begin
      blk = '0;
      blk[64*f +: 64] = 64'hffff_ffff_ffff_ffff;
      send_block(blk);
    end
    send_block({16{32'h8000_0000}});
    send_block({16{32'h7fff_ffff}});
    send_block({16{32'h0000_0001}});
    // word k holds k: tells words apart if the routing is off
    for (int k = 0; k < 16; k++) blk[32*k +: 32] = k;
    send_block(blk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender mostly busy, receiver mostly stalled: pipeline fills, backpressure
    send_idle_pct  = 22;
    recv_stall_pct = 85;
    send_directed();
    repeat (PHASE_BLOCKS) send_block(random_block());

    // sender mostly idle, receiver mostly ready: bubbles through the stages
    send_idle_pct  = 85;
    recv_stall_pct = 22;
    repeat (PHASE_BLOCKS) send_block(random_block());

    // full rate both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (PHASE_BLOCKS) send_block(random_block());
    s_axis_tvalid <= 1'b0;

    while (sb.predicted.size() != 0) @(posedge clk);
    // catch stray results past the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
